// File: design/psg_pkg.sv
// psg_pkg: shared types, constants and the attenuation lookup for the PSG tone generator.
// No dependencies.
`timescale 1ns / 1ps

package psg_pkg;

  localparam int NUM_CH = 3;
  localparam int PER_W = 10;
  localparam int LVL_W = 7;

  typedef logic [PER_W-1:0] period_t;
  typedef logic [LVL_W-1:0] level_t;

  // One byte-port write, as handed from the input register to the register file.
  typedef struct packed {
    logic       en;
    logic [7:0] data;
  } psg_wr_t;

  // Index of the noise control register: even, but not a tone period.
  localparam logic [2:0] IDX_NOISE = 3'd6;

  // 4-bit attenuation code to linear amplitude.
  function automatic level_t atten_lookup(input logic [3:0] code);
    level_t lvl;
    case (code)
      4'd0:    lvl = 7'd64;
      4'd1:    lvl = 7'd50;
      4'd2:    lvl = 7'd39;
      4'd3:    lvl = 7'd31;
      4'd4:    lvl = 7'd24;
      4'd5:    lvl = 7'd19;
      4'd6:    lvl = 7'd15;
      4'd7:    lvl = 7'd12;
      4'd8:    lvl = 7'd9;
      4'd9:    lvl = 7'd7;
      4'd10:   lvl = 7'd5;
      4'd11:   lvl = 7'd4;
      4'd12:   lvl = 7'd3;
      4'd13:   lvl = 7'd2;
      4'd14:   lvl = 7'd1;
      default: lvl = 7'd0;
    endcase
    return lvl;
  endfunction

endpackage

// File: design/psg_regs.sv
// psg_regs: latch/data byte decoder, tone period registers and volume levels.
// Depends on psg_pkg.
`timescale 1ns / 1ps

module psg_regs (
  input  logic             clk,
  input  logic             rst_n,
  input  psg_pkg::psg_wr_t wr,
  output psg_pkg::period_t period [psg_pkg::NUM_CH],
  output psg_pkg::level_t  volume [psg_pkg::NUM_CH]
);
  import psg_pkg::*;

  logic [2:0] idx_r, idx_nxt;
  period_t    period_r [NUM_CH];
  level_t     volume_r [NUM_CH];
  logic       is_latch;

  assign is_latch = wr.data[7];
  // A latch byte retargets the index before the write lands.
  assign idx_nxt  = is_latch ? wr.data[6:4] : idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      for (int c = 0; c < NUM_CH; c++) begin
        period_r[c] <= '0;
        volume_r[c] <= '0;
      end
    end else if (wr.en) begin
      idx_r <= idx_nxt;
      for (int c = 0; c < NUM_CH; c++) begin
        if (idx_nxt == 3'(2 * c)) begin
          if (is_latch) begin
            period_r[c][3:0] <= wr.data[3:0];
          end else begin
            period_r[c][9:4] <= wr.data[5:0];
          end
        end
        if (idx_nxt == 3'(2 * c + 1)) begin
          volume_r[c] <= atten_lookup(wr.data[3:0]);
        end
      end
    end
  end

  assign period = period_r;
  assign volume = volume_r;

endmodule

// File: design/psg_tone_ch.sv
// psg_tone_ch: one square-wave tone channel (down counter, phase, held level).
// Depends on psg_pkg.
`timescale 1ns / 1ps

module psg_tone_ch (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  psg_pkg::period_t period,
  input  psg_pkg::level_t  volume,
  output psg_pkg::level_t  level
);
  import psg_pkg::*;

  period_t cnt_r;
  logic    phase_r, phase_nxt;
  level_t  held_r;
  logic    at_end;

  assign at_end = (cnt_r <= PER_W'(1));
  // Zero period parks the output low.
  assign phase_nxt = (period == '0) ? 1'b0 : ~phase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      phase_r <= 1'b0;
      held_r  <= '0;
    end else if (step) begin
      if (at_end) begin
        cnt_r   <= period;
        phase_r <= phase_nxt;
        held_r  <= phase_nxt ? volume : '0;
      end else begin
        cnt_r <= cnt_r - PER_W'(1);
      end
    end
  end

  assign level = held_r;

endmodule

// File: design/psg_tone_generator.sv
// psg_tone_generator: top level of the three-channel PSG tone generator.
// Depends on psg_pkg, psg_regs and psg_tone_ch.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid / in_stall): each word is either a byte write to the
//   chip's latch/data port (in_action = 0, byte on in_data) or a master clock
//   tick (in_action = 1, in_data ignored).
//   Output channel (out_valid / out_stall): exactly one word per input word, in
//   order: the held amplitude of each tone channel after that word took effect,
//   and out_stepped = 1 when the word wrapped the prescaler from 15 to 0.
//   Pipeline: two register stages (input register, then state and result
//   registers). Throughput: one word per cycle while out_stall is low.
//   The rate is set by the single state update per cycle: the register file,
//   prescaler and the three channel counters all update in the same cycle the
//   result register loads.
//   Stall: while out_stall holds a valid result, the state freezes; the input
//   register still takes one word, then keeps it and raises in_stall; nothing
//   is dropped.
//   Reset (rst_n low, synchronous): periods, volumes, counters, phases, levels,
//   prescaler and latched index clear; both pipeline stages empty.
module psg_tone_generator (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_action,
  input  logic [7:0]             in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [6:0]             out_level_ch0,
  output logic [6:0]             out_level_ch1,
  output logic [6:0]             out_level_ch2,
  output logic                   out_stepped
);
  import psg_pkg::*;

  // Input register stage.
  logic       iv_r;
  logic       act_r;
  logic [7:0] data_r;

  // Result stage control.
  logic       ov_r;
  logic       stepped_r, stepped_nxt;
  logic [3:0] presc_r, presc_nxt;

  logic       advance;   // result register may load this cycle
  logic       fire;      // word in input register is processed now
  logic       step;
  psg_wr_t    wr;

  period_t    period [NUM_CH];
  level_t     volume [NUM_CH];
  level_t     level  [NUM_CH];

  assign advance  = ~ov_r | ~out_stall;
  assign fire     = iv_r & advance;
  assign in_stall = iv_r & ~advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
    end else if (!in_stall) begin
      iv_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      act_r  <= in_action;
      data_r <= in_data;
    end
  end

  // Prescaler: a tone step happens when it wraps 15 -> 0.
  assign presc_nxt   = presc_r + 4'd1;
  assign step        = fire & act_r & (presc_nxt == 4'd0);
  assign stepped_nxt = act_r & (presc_nxt == 4'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      presc_r   <= '0;
      ov_r      <= 1'b0;
      stepped_r <= 1'b0;
    end else if (advance) begin
      ov_r <= iv_r;
      if (iv_r) begin
        stepped_r <= stepped_nxt;
        if (act_r) begin
          presc_r <= presc_nxt;
        end
      end
    end
  end

  assign wr.en   = fire & ~act_r;
  assign wr.data = data_r;

  psg_regs u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (wr),
    .period (period),
    .volume (volume)
  );

  // Held levels only change on a processed word, so they double as the
  // result register's level fields.
  for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
    psg_tone_ch u_ch (
      .clk    (clk),
      .rst_n  (rst_n),
      .step   (step),
      .period (period[c]),
      .volume (volume[c]),
      .level  (level[c])
    );
  end

  assign out_valid     = ov_r;
  assign out_level_ch0 = level[0];
  assign out_level_ch1 = level[1];
  assign out_level_ch2 = level[2];
  assign out_stepped   = stepped_r;

endmodule
